// ===== rtl/whash_pkg.sv =====
// Shared constants and types for the word-mix string hash unit.
package whash_pkg;

  localparam logic [63:0] MIX_M1     = 64'h9ddfea08eb382d69;
  localparam logic [63:0] MIX_M2     = 64'hc3a5c85c97cb3127;
  localparam logic [63:0] SEED_BASIS = 64'd1469598103934665603;
  localparam logic [63:0] ROUND_MUL  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FINAL_MUL  = 64'hc4ceb9fe1a85ec53;

  localparam int unsigned ROT_LEFT   = 31;
  localparam int unsigned MIX_SHIFT  = 33;

  typedef logic [63:0] word_t;
  typedef logic [3:0]  nbytes_t;
  typedef logic [31:0] len_t;

  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

endpackage

// ===== rtl/word_mix_string_hash64_unit.sv =====
// Top level: word-mix 64-bit string hash, sequencer around one shared multiplier.
//
//   channel | direction | ports                                          | beat when
//   in      | input     | in_word, in_valid_bytes, in_total_length,      | in_valid & in_ready
//           |           | in_last                                        |
//   out     | output    | out_hash_value                                 | out_valid & out_ready
//
// A word with valid bytes takes three chained multiplies, a last word one more.
// Each multiply runs as three partial products on the one 32x32 multiplier inside
// whash_mul64. An empty last word takes only the final multiply, and an empty
// word that is not last takes none.
// Reset clears the sequencer and the running hash; the next word starts a message.
// in_ready is low while a word is in work; a finished hash waits in the output
// register, and a following message may run up to its own finish meanwhile.
module word_mix_string_hash64_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  whash_pkg::word_t    in_word,
  input  whash_pkg::nbytes_t  in_valid_bytes,
  input  whash_pkg::len_t     in_total_length,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output whash_pkg::word_t    out_hash_value
);
  import whash_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_RND,
    S_FIN,
    S_OUT
  } state_t;

  state_t   state_r;
  word_t    hash_r;
  word_t    run_hash_r;
  logic     at_start_r;
  logic     last_r;
  logic     out_valid_r;
  word_t    out_hash_r;
  mul_req_t req_r;
  mul_rsp_t rsp;

  word_t    seed;
  word_t    key;
  word_t    byte_mask;
  word_t    mixed;
  word_t    rot_key;

  whash_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  assign seed = at_start_r ? (SEED_BASIS ^ 64'(in_total_length)) : run_hash_r;

  always_comb begin
    if (in_valid_bytes >= 4'd8) begin
      byte_mask = '1;
    end else begin
      byte_mask = (64'd1 << {in_valid_bytes[2:0], 3'b000}) - 64'd1;
    end
  end

  assign key     = in_word & byte_mask;
  assign rot_key = (rsp.prod << ROT_LEFT) | (rsp.prod >> (64 - ROT_LEFT));
  assign mixed   = (hash_r ^ rsp.prod) ^ ((hash_r ^ rsp.prod) >> MIX_SHIFT);

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_hash_r  <= '0;
      at_start_r  <= 1'b1;
      out_valid_r <= 1'b0;
      req_r.start <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_last;
            if (in_valid_bytes != 4'd0) begin
              hash_r      <= seed;
              req_r.start <= 1'b1;
              req_r.op_a  <= key;
              req_r.op_b  <= MIX_M1;
              state_r     <= S_K1;
            end else if (in_last) begin
              hash_r      <= seed;
              req_r.start <= 1'b1;
              req_r.op_a  <= seed ^ (seed >> MIX_SHIFT);
              req_r.op_b  <= FINAL_MUL;
              state_r     <= S_FIN;
            end else begin
              req_r.start <= 1'b0;
              run_hash_r  <= seed;
              at_start_r  <= 1'b0;
            end
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_K1: begin
          if (rsp.done) begin
            req_r.start <= 1'b1;
            req_r.op_a  <= rot_key;
            req_r.op_b  <= MIX_M2;
            state_r     <= S_K2;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_K2: begin
          if (rsp.done) begin
            req_r.start <= 1'b1;
            req_r.op_a  <= mixed;
            req_r.op_b  <= ROUND_MUL;
            state_r     <= S_RND;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_RND: begin
          if (rsp.done) begin
            if (last_r) begin
              req_r.start <= 1'b1;
              req_r.op_a  <= rsp.prod ^ (rsp.prod >> MIX_SHIFT);
              req_r.op_b  <= FINAL_MUL;
              state_r     <= S_FIN;
            end else begin
              req_r.start <= 1'b0;
              run_hash_r  <= rsp.prod;
              at_start_r  <= 1'b0;
              state_r     <= S_IDLE;
            end
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_FIN: begin
          req_r.start <= 1'b0;
          if (rsp.done) begin
            hash_r  <= rsp.prod ^ (rsp.prod >> MIX_SHIFT);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          req_r.start <= 1'b0;
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_hash_r  <= hash_r;
            run_hash_r  <= hash_r;
            at_start_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          req_r.start <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/whash_mul64.sv =====
// Iterative 64x64 multiplier, low 64 bits, from three 32x32 partial products.
module whash_mul64 (
  input  logic                clk,
  input  logic                rst_n,
  input  whash_pkg::mul_req_t req,
  output whash_pkg::mul_rsp_t rsp
);
  import whash_pkg::*;

  logic [1:0]  phase_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] part_r;
  word_t       acc_r;

  always_comb begin
    case (phase_r)
      2'd0: begin
        mul_a = req.op_a[31:0];
        mul_b = req.op_b[31:0];
      end
      2'd1: begin
        mul_a = req.op_a[31:0];
        mul_b = req.op_b[63:32];
      end
      default: begin
        mul_a = req.op_a[63:32];
        mul_b = req.op_b[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= busy_r && !req.start && (phase_r == 2'd3);
      if (req.start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    part_r <= 64'(mul_a) * 64'(mul_b);
    case (phase_r)
      2'd0:    acc_r <= acc_r;
      2'd1:    acc_r <= part_r;
      default: acc_r <= acc_r + {part_r[31:0], 32'd0};
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== sim/word_mix_string_hash64_unit_test.sv =====
// Testbench for word_mix_string_hash64_unit: directed and random messages checked against a model.
module word_mix_string_hash64_unit_test;
  import whash_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned PRESSURE_HOLD = 400;
  localparam int unsigned TAIL_CYCLES = 60;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  word_t    in_word;
  nbytes_t  in_valid_bytes;
  len_t     in_total_length;
  logic     in_last;
  logic     out_valid;
  logic     out_ready;
  word_t    out_hash_value;

  word_t        hash_expect[$];
  word_t        model_hash;
  logic         model_fresh;
  int unsigned  words_sent;
  int unsigned  messages_sent;
  int unsigned  hashes_checked;
  int unsigned  err_count;
  int unsigned  burst_left;
  int unsigned  hold_cycles;
  int unsigned  cycle_count;

  word_mix_string_hash64_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_total_length (in_total_length),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d hashes still pending", cycle_count,
             hash_expect.size());
    $display("word_mix_string_hash64_unit regression: fail");
    $finish;
  end

  // Receiver: long hold on request, otherwise a changing stall pattern.
  initial begin
    int unsigned pat_mode;
    int unsigned pat_left;
    int unsigned phase;
    pat_mode = 0;
    pat_left = 0;
    phase = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 200);
      end
      pat_left--;
      phase++;
      case (pat_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= (phase % 7) > 2;
        end
        default: begin
          out_ready <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  // Result check against the oldest expected hash.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (hash_expect.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected hash beat %h", out_hash_value);
      end else begin
        if (out_hash_value !== hash_expect[0]) begin
          err_count++;
          if (err_count <= 10)
            $display("hash mismatch: expected %h got %h", hash_expect[0], out_hash_value);
        end
        void'(hash_expect.pop_front());
        hashes_checked++;
      end
    end
  end

  // Advance the model by one accepted word; queue the hash when the message ends.
  task automatic mix_word(input word_t w, input nbytes_t nb, input len_t len,
                          input logic lst);
    word_t       h;
    word_t       k;
    int unsigned n;
    n = (nb > 8) ? 8 : nb;
    h = model_fresh ? (SEED_BASIS ^ {32'd0, len}) : model_hash;
    if (n != 0) begin
      k = (n == 8) ? w : (w & ((64'd1 << (8 * n)) - 64'd1));
      k = k * MIX_M1;
      k = {k[32:0], k[63:33]};
      k = k * MIX_M2;
      h = h ^ k;
      h = (h ^ (h >> MIX_SHIFT)) * ROUND_MUL;
    end
    if (lst) begin
      h = h ^ (h >> MIX_SHIFT);
      h = h * FINAL_MUL;
      h = h ^ (h >> MIX_SHIFT);
      hash_expect.push_back(h);
      messages_sent++;
    end
    model_hash = h;
    model_fresh = lst;
    words_sent++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_word(input word_t w, input nbytes_t nb, input len_t len,
                           input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    in_valid_bytes <= nb;
    in_total_length <= len;
    in_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_word(w, nb, len, lst);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic sender_stop();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
  endtask

  task automatic drain();
    sender_stop();
    while (hash_expect.size() != 0) @(negedge clk);
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_message(input int unsigned nwords, input bit tidy);
    int unsigned tail;
    len_t        len;
    nbytes_t     nb;
    bit          lst;
    tail = $urandom_range(1, 8);
    len = (nwords - 1) * 8 + tail;
    if (tidy && nwords == 1 && $urandom_range(0, 9) == 0) begin
      tail = 0;
      len = 0;
    end
    if (!tidy)
      len = $urandom;
    for (int unsigned i = 0; i < nwords; i++) begin
      lst = (i == nwords - 1);
      if (tidy)
        nb = lst ? nbytes_t'(tail) : 4'd8;
      else
        nb = nbytes_t'($urandom_range(0, 15));
      send_word(rand_word(), nb, len, lst);
    end
  endtask

  task automatic test_empty_message();
    send_word('0, 4'd0, 32'd0, 1'b1);
    send_word(rand_word(), 4'd0, $urandom, 1'b1);
    drain();
  endtask

  // Lone words over every byte count, including counts above eight.
  task automatic test_byte_counts();
    word_t w;
    len_t  len;
    for (int unsigned nb = 0; nb < 16; nb++) begin
      w = (nb % 2 == 0) ? '1 : rand_word();
      case (nb % 3)
        0: len = 32'd0;
        1: len = '1;
        default: len = nb;
      endcase
      send_word(w, nbytes_t'(nb), len, 1'b1);
    end
    send_word('0, 4'd8, 32'd8, 1'b1);
    drain();
  endtask

  // Partial word before the last, empty last and first words, a wrong length.
  task automatic test_irregular_messages();
    send_word(rand_word(), 4'd3, 32'd11, 1'b0);
    send_word('1, 4'd8, 32'd11, 1'b0);
    send_word(rand_word(), 4'd0, 32'd11, 1'b1);
    send_word(rand_word(), 4'd0, '1, 1'b0);
    send_word(rand_word(), 4'd5, 32'd0, 1'b1);
    drain();
  endtask

  // Receiver holds off while short messages keep coming, so the input stalls.
  task automatic test_output_backpressure();
    hold_cycles = PRESSURE_HOLD;
    for (int i = 0; i < 20; i++)
      send_message($urandom_range(1, 2), 1'b1);
    drain();
  endtask

  task automatic test_random_messages();
    int unsigned start_words;
    int unsigned nwords;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      nwords = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4);
      send_message(nwords, $urandom_range(0, 4) != 0);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    in_valid_bytes = '0;
    in_total_length = '0;
    in_last = 1'b0;
    hold_cycles = 0;
    burst_left = 0;
    words_sent = 0;
    messages_sent = 0;
    hashes_checked = 0;
    err_count = 0;
    model_hash = '0;
    model_fresh = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_message();
    test_byte_counts();
    test_irregular_messages();
    test_output_backpressure();
    test_random_messages();

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("ran %0d words in %0d messages, %0d hashes compared, %0d errors",
             words_sent, messages_sent, hashes_checked, err_count);
    $display("covered empty and partial words, byte counts 0..15, %0d-cycle output hold",
             PRESSURE_HOLD);
    if (err_count == 0 && hash_expect.size() == 0)
      $display("word_mix_string_hash64_unit regression: pass");
    else
      $display("word_mix_string_hash64_unit regression: fail");
    $finish;
  end

endmodule
